// ===== hdl/bqc_pkg.sv =====
`default_nettype none

package bqc_pkg;

  localparam logic [1:0] KIND_FILTER = 2'd0;
  localparam logic [1:0] KIND_COEF   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam int COEF_W      = 24;
  localparam int CFG_W       = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] op;
    logic       chan;
    logic [4:0] addr;
  } bqc_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bqc_front.sv =====
`default_nettype none

module bqc_front #(
  parameter int MAX_SECTIONS = 8,
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_BITS  = 24,
  parameter int DW           = 24
) (
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           kind,
  input  wire logic                                 channel,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample,
  input  wire logic [4:0]                           coef_index,
  input  wire logic signed [bqc_pkg::COEF_W-1:0]    coef_value,
  input  wire logic                                 q_full,
  output logic                                      push,
  output bqc_pkg::bqc_cmd_t                         cmd,
  output logic [DW-1:0]                             data
);

  logic keep;

  always_comb begin
    keep = 1'b0;
    if (32'(channel) < CHANNELS) begin
      unique case (kind)
        bqc_pkg::KIND_FILTER: keep = 1'b1;
        bqc_pkg::KIND_CLEAR:  keep = 1'b1;
        bqc_pkg::KIND_COEF:   keep = (32'(coef_index) < 4 * MAX_SECTIONS);
        default:              keep = 1'b0;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && keep;
  assign cmd.op   = kind;
  assign cmd.chan = channel;
  assign cmd.addr = coef_index;
  assign data     = (kind == bqc_pkg::KIND_COEF) ? DW'(coef_value) : DW'(sample);

endmodule

`default_nettype wire

// ===== hdl/bqc_queue.sv =====
`default_nettype none

module bqc_queue #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              full,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqc_back.sv =====
`default_nettype none

module bqc_back #(
  parameter int MAX_SECTIONS = 8,
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_BITS  = 24,
  parameter int DW           = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire bqc_pkg::bqc_cmd_t             q_cmd,
  input  wire logic [DW-1:0]                 q_data,
  output logic                               q_pop,
  input  wire logic [bqc_pkg::CFG_W-1:0]     num_sections,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_channel,
  output logic signed [SAMPLE_BITS-1:0]      filtered,
  output logic                               saturated
);

  localparam int ROWS    = CHANNELS * MAX_SECTIONS;
  localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int STATE_W = 40;
  localparam int PROD_W  = 42;
  localparam int ACC_W   = 44;
  localparam int CW      = bqc_pkg::COEF_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_Y    = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_M3   = 3'd4;
  localparam logic [2:0] S_W0   = 3'd5;
  localparam logic [2:0] S_W1   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  function automatic logic signed [STATE_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if ((&v[ACC_W-1:STATE_W-1]) || !(|v[ACC_W-1:STATE_W-1])) begin
      r = v[STATE_W-1:0];
    end else begin
      r = {v[ACC_W-1], {(STATE_W - 1){~v[ACC_W-1]}}};
    end
    return r;
  endfunction

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [SW-1:0]             sec;
  logic                      ch;
  logic signed [STATE_W-1:0] x;
  logic signed [STATE_W-1:0] y;
  logic signed [ACC_W-1:0]   acc;
  logic signed [STATE_W-1:0] s0r;
  logic signed [STATE_W-1:0] s1r;
  logic                      rvld;
  logic signed [CW-1:0]      cw [4];
  logic signed [44:0]        pp_lo;
  logic signed [43:0]        pp_hi;
  logic signed [PROD_W-1:0]  prod;
  logic                      svld [ROWS];
  logic                      cvld [4][MAX_SECTIONS];
  logic signed [STATE_W-1:0] s0mem [ROWS];
  logic signed [STATE_W-1:0] s1mem [ROWS];
  logic signed [CW-1:0]      cmem [4][MAX_SECTIONS];

  logic [bqc_pkg::CFG_W-1:0] neff;
  logic                      last;
  logic                      take_filter;
  logic                      rd_en;
  logic [SW-1:0]             rd_sec;
  logic                      rd_ch;
  logic [RW-1:0]             rd_row;
  logic [RW-1:0]             cur_row;
  logic signed [STATE_W-1:0] x_in;
  logic signed [STATE_W-1:0] s0v;
  logic signed [STATE_W-1:0] s1v;
  logic signed [STATE_W-1:0] y_calc;
  logic signed [STATE_W-1:0] msig;
  logic signed [CW-1:0]      mcoef;
  logic signed [20:0]        mlo;
  logic signed [19:0]        mhi;
  logic signed [63:0]        mfull;
  logic [1:0]                wword;
  logic [SW-1:0]             wsec;
  logic signed [STATE_W:0]   rsum;
  logic signed [32:0]        r33;
  logic                      clip;
  logic                      load_out;

  assign neff = (32'(num_sections) > MAX_SECTIONS) ? bqc_pkg::CFG_W'(MAX_SECTIONS)
                                                   : num_sections;
  assign last        = ((6'(sec) + 6'd1) >= 6'(neff));
  assign q_pop       = (state == S_IDLE) && !q_empty;
  assign take_filter = q_pop && (q_cmd.op == bqc_pkg::KIND_FILTER);
  assign rd_en       = (take_filter && (neff != '0)) || ((state == S_W0) && !last);
  assign rd_sec      = (state == S_IDLE) ? '0 : sec + 1'b1;
  assign rd_ch       = (state == S_IDLE) ? q_cmd.chan : ch;
  assign rd_row      = RW'(int'(rd_ch) * MAX_SECTIONS + int'(rd_sec));
  assign cur_row     = RW'(int'(ch) * MAX_SECTIONS + int'(sec));
  assign x_in        = STATE_W'(signed'(q_data[SAMPLE_BITS-1:0])) <<< 8;
  assign s0v         = rvld ? s0r : '0;
  assign s1v         = rvld ? s1r : '0;
  assign y_calc      = sat40(ACC_W'(x) + ACC_W'(s0v));
  assign wword       = q_cmd.addr[1:0];
  assign wsec        = SW'(q_cmd.addr >> 2);
  assign load_out    = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    unique case (state)
      S_Y:     begin msig = x; mcoef = cw[3]; end
      S_M1:    begin msig = y; mcoef = cw[1]; end
      S_M2:    begin msig = x; mcoef = cw[2]; end
      default: begin msig = y; mcoef = cw[0]; end
    endcase
    mlo   = signed'({1'b0, msig[19:0]});
    mhi   = msig[STATE_W-1:20];
    mfull = (64'(pp_hi) <<< 20) + 64'(pp_lo) + (64'sd1 <<< 21);
  end

  always_comb begin
    rsum = (STATE_W + 1)'(y) + (STATE_W + 1)'(128);
    r33  = rsum[STATE_W:8];
    clip = !((&r33[32:SAMPLE_BITS-1]) || !(|r33[32:SAMPLE_BITS-1]));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take_filter) begin
          state_next = (neff == '0) ? S_OUT : S_Y;
        end
      end
      S_Y:  state_next = S_M1;
      S_M1: state_next = S_M2;
      S_M2: state_next = S_M3;
      S_M3: state_next = S_W0;
      S_W0: state_next = S_W1;
      S_W1: state_next = last ? S_OUT : S_Y;
      S_OUT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        svld[r] <= 1'b0;
      end
      for (int k = 0; k < 4; k++) begin
        for (int s = 0; s < MAX_SECTIONS; s++) begin
          cvld[k][s] <= 1'b0;
        end
      end
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop && (q_cmd.op == bqc_pkg::KIND_COEF)) begin
        cvld[wword][wsec] <= 1'b1;
      end
      if (q_pop && (q_cmd.op == bqc_pkg::KIND_CLEAR)) begin
        for (int r = 0; r < ROWS; r++) begin
          if ((r / MAX_SECTIONS) == int'(q_cmd.chan)) begin
            svld[r] <= 1'b0;
          end
        end
      end
      if (state == S_W1) begin
        svld[cur_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s0r  <= s0mem[rd_row];
      s1r  <= s1mem[rd_row];
      rvld <= svld[rd_row];
      for (int k = 0; k < 4; k++) begin
        cw[k] <= cvld[k][rd_sec] ? cmem[k][rd_sec] : '0;
      end
    end
    if (state == S_W0) begin
      s0mem[cur_row] <= sat40(acc);
    end
    if (state == S_W1) begin
      s1mem[cur_row] <= sat40(acc + ACC_W'(prod));
    end
    if (q_pop && (q_cmd.op == bqc_pkg::KIND_COEF)) begin
      cmem[wword][wsec] <= q_data[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pp_lo <= mlo * mcoef;
    pp_hi <= mhi * mcoef;
    prod  <= mfull[63:22];
    unique case (state)
      S_IDLE: begin
        if (take_filter) begin
          ch  <= q_cmd.chan;
          x   <= x_in;
          y   <= x_in;
          sec <= '0;
        end
      end
      S_Y:  y   <= y_calc;
      S_M2: acc <= ACC_W'(prod);
      S_M3: acc <= acc + ACC_W'(prod) + ACC_W'(s1v);
      S_W0: acc <= ACC_W'(prod);
      S_W1: begin
        x <= y;
        if (!last) begin
          sec <= sec + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_channel <= ch;
      saturated   <= clip;
      filtered    <= clip ? {r33[32], {(SAMPLE_BITS - 1){~r33[32]}}}
                          : r33[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/biquad_cascade_iir_filter.sv =====
// A sample item popped in S_IDLE runs S_Y, S_M1, S_M2, S_M3, S_W0 and S_W1 per active
// section, or none with no active sections, then loads out_valid from S_OUT.
// The back end shares one split multiplier and takes no new item until S_OUT is left.
// Coefficient and clear items retire at one per cycle through a four-entry queue while the back end is in S_IDLE.
// Reset is synchronous: num_sections returns to 1, all stored state and coefficients
// read as zero at once through per-row and per-word valid bits, with no clearing pass.
`default_nettype none

module biquad_cascade_iir_filter #(
  parameter int MAX_SECTIONS = 8,
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_BITS  = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bqc_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         kind,
  input  wire logic                               channel,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample,
  input  wire logic [4:0]                         coef_index,
  input  wire logic signed [bqc_pkg::COEF_W-1:0]  coef_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_channel,
  output logic signed [SAMPLE_BITS-1:0]           filtered,
  output logic                                    saturated
);

  localparam int DW = (SAMPLE_BITS > bqc_pkg::COEF_W) ? SAMPLE_BITS : bqc_pkg::COEF_W;
  localparam int QW = $bits(bqc_pkg::bqc_cmd_t) + DW;

  logic [bqc_pkg::CFG_W-1:0] num_sections;
  logic                      push;
  bqc_pkg::bqc_cmd_t         f_cmd;
  logic [DW-1:0]             f_data;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  logic [QW-1:0]             q_rdata;
  bqc_pkg::bqc_cmd_t         q_cmd;
  logic [DW-1:0]             q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sections <= bqc_pkg::CFG_W'(1);
    end else if (cfg_valid) begin
      num_sections <= cfg_data;
    end
  end

  bqc_front #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .CHANNELS     (CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .DW           (DW)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .channel    (channel),
    .sample     (sample),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .q_full     (q_full),
    .push       (push),
    .cmd        (f_cmd),
    .data       (f_data)
  );

  bqc_queue #(
    .W     (QW),
    .DEPTH (bqc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_cmd, f_data}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_cmd  = q_rdata[QW-1:DW];
  assign q_data = q_rdata[DW-1:0];

  bqc_back #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .CHANNELS     (CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .DW           (DW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_cmd        (q_cmd),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .num_sections (num_sections),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .filtered     (filtered),
    .saturated    (saturated)
  );

endmodule

`default_nettype wire

// ===== hdl/bqc_checker.sv =====
`default_nettype none

module bqc_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   out_channel,
  input wire logic [SAMPLE_BITS-1:0] filtered,
  input wire logic                   saturated
);

  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered) &&
                                $stable(out_channel) && $stable(saturated))
    else $error("output item changed while stalled");

  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (filtered == SMAX) || (filtered == SMIN))
    else $error("clipped item is not at a rail");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not empty the block");

endmodule

bind biquad_cascade_iir_filter bqc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bqc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_channel (out_channel),
  .filtered    (filtered),
  .saturated   (saturated)
);

`default_nettype wire

// ===== test/tb_biquad_cascade_iir_filter.sv =====
`default_nettype none

module tb_biquad_cascade_iir_filter;

  localparam int SECTIONS = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint STATE_HI = 64'sd549755813887;
  localparam longint STATE_LO = -64'sd549755813888;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 64;

  typedef struct {
    logic [1:0] op;
    logic chan;
    logic signed [23:0] smp;
    logic [4:0] slot;
    logic signed [23:0] word;
  } stim_t;

  typedef struct {
    logic chan;
    logic signed [23:0] value;
    logic clip;
  } audio_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bqc_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = bqc_pkg::KIND_FILTER;
  logic channel = 1'b0;
  logic signed [23:0] sample = '0;
  logic [4:0] coef_index = '0;
  logic signed [bqc_pkg::COEF_W-1:0] coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_channel;
  logic signed [23:0] filtered;
  logic saturated;

  biquad_cascade_iir_filter dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .channel(channel),
    .sample(sample),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_channel(out_channel),
    .filtered(filtered),
    .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [23:0] coef_mem [32];
  longint sec_state [2][SECTIONS][2];
  logic [3:0] sections_cfg;

  stim_t stim_q[$];
  stim_t nxt;
  audio_out_t filtered_due[$];
  audio_out_t want;
  int send_gap;
  int recv_gap;
  int idle_pct;
  int errors;
  int results_seen;
  int coef_writes;
  int clears;
  int ignored;
  int cfg_writes;

  function automatic longint clamp40(longint v);
    if (v > STATE_HI) return STATE_HI;
    if (v < STATE_LO) return STATE_LO;
    return v;
  endfunction

  function automatic longint scale_q22(longint sig, logic signed [23:0] c);
    longint cw;
    cw = longint'(c);
    return (sig * cw + 64'sd2097152) >>> 22;
  endfunction

  function automatic logic signed [23:0] rand24();
    logic [31:0] rnd;
    rnd = $urandom();
    return rnd[23:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    errors++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  task automatic run_cascade(input logic [1:0] op, input logic chan,
                             input logic signed [23:0] smp, input logic [4:0] slot,
                             input logic signed [23:0] word);
    longint x;
    longint y;
    longint r;
    longint s0n;
    longint s1n;
    int n;
    int j;
    audio_out_t res;
    case (op)
      bqc_pkg::KIND_COEF: begin
        coef_mem[slot] = word;
        coef_writes++;
      end
      bqc_pkg::KIND_CLEAR: begin
        for (j = 0; j < SECTIONS; j++) begin
          sec_state[chan][j][0] = 0;
          sec_state[chan][j][1] = 0;
        end
        clears++;
      end
      bqc_pkg::KIND_FILTER: begin
        n = (sections_cfg > SECTIONS) ? SECTIONS : int'(sections_cfg);
        x = longint'(smp);
        x = x * 256;
        y = x;
        for (j = 0; j < n; j++) begin
          y = clamp40(x + sec_state[chan][j][0]);
          s0n = clamp40(scale_q22(x, coef_mem[j*4+3]) + scale_q22(y, coef_mem[j*4+1])
                        + sec_state[chan][j][1]);
          s1n = clamp40(scale_q22(x, coef_mem[j*4+2]) + scale_q22(y, coef_mem[j*4]));
          sec_state[chan][j][0] = s0n;
          sec_state[chan][j][1] = s1n;
          x = y;
        end
        r = (y + 128) >>> 8;
        res.clip = 1'b0;
        if (r > SAMPLE_HI) begin
          r = SAMPLE_HI;
          res.clip = 1'b1;
        end
        if (r < SAMPLE_LO) begin
          r = SAMPLE_LO;
          res.clip = 1'b1;
        end
        res.chan = chan;
        res.value = r[23:0];
        filtered_due.push_back(res);
      end
      default: begin
        ignored++;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        run_cascade(kind, channel, sample, coef_index, coef_value);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          nxt = stim_q.pop_front();
          in_valid <= 1'b1;
          kind <= nxt.op;
          channel <= nxt.chan;
          sample <= nxt.smp;
          coef_index <= nxt.slot;
          coef_value <= nxt.word;
          if ($urandom_range(99) < idle_pct) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_due.size() == 0) begin
          report_mismatch("result with none due, filtered", longint'(filtered), 0);
        end else begin
          want = filtered_due.pop_front();
          if (out_channel !== want.chan) begin
            report_mismatch("out_channel", longint'(out_channel), longint'(want.chan));
          end
          if (filtered !== want.value) begin
            report_mismatch("filtered", longint'(filtered), longint'(want.value));
          end
          if (saturated !== want.clip) begin
            report_mismatch("saturated", longint'(saturated), longint'(want.clip));
          end
          results_seen++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        recv_gap = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic chan,
                           input logic signed [23:0] smp, input logic [4:0] slot,
                           input logic signed [23:0] word);
    stim_t it;
    it.op = op;
    it.chan = chan;
    it.smp = smp;
    it.slot = slot;
    it.word = word;
    stim_q.push_back(it);
  endtask

  task automatic write_sections(input logic [3:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sections_cfg = v;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (stim_q.size() > 0 || in_valid) @(posedge clk);
    while (filtered_due.size() > 0 && waited < 3000) begin
      @(posedge clk);
      waited++;
    end
    while (filtered_due.size() > 0) begin
      report_mismatch("missing result, filtered", 0, longint'(filtered_due[0].value));
      filtered_due.delete(0);
    end
    repeat (60) @(posedge clk);
  endtask

  // Poles stay inside the unit circle so that most of a phase runs unclipped.
  task automatic load_stable(input int sec);
    int a2;
    int a1lim;
    int a1;
    a2 = int'($urandom_range(5872026)) - 2936013;
    a1lim = ((4194304 + a2) / 10) * 8;
    a1 = int'($urandom_range(2 * a1lim)) - a1lim;
    push_item(bqc_pkg::KIND_COEF, 1'($urandom_range(1)), rand24(), 5'(sec * 4), 24'(-a2));
    push_item(bqc_pkg::KIND_COEF, 1'($urandom_range(1)), rand24(), 5'(sec * 4 + 1), 24'(-a1));
    push_item(bqc_pkg::KIND_COEF, 1'($urandom_range(1)), rand24(), 5'(sec * 4 + 2),
              24'(int'($urandom_range(4194304)) - 2097152));
    push_item(bqc_pkg::KIND_COEF, 1'($urandom_range(1)), rand24(), 5'(sec * 4 + 3),
              24'(int'($urandom_range(4194304)) - 2097152));
  endtask

  initial begin
    logic [3:0] phase_cfg [PHASES];
    logic signed [23:0] smp;
    int ph;
    int i;
    int pick;
    int style;
    phase_cfg = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd6, 4'd12, 4'd2};
    errors = 0;
    results_seen = 0;
    coef_writes = 0;
    clears = 0;
    ignored = 0;
    cfg_writes = 0;
    idle_pct = 20;
    sections_cfg = 4'd1;
    for (i = 0; i < 32; i++) coef_mem[i] = '0;
    for (i = 0; i < SECTIONS; i++) begin
      sec_state[0][i][0] = 0;
      sec_state[0][i][1] = 0;
      sec_state[1][i][0] = 0;
      sec_state[1][i][1] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_sections(4'd1);
    push_item(bqc_pkg::KIND_FILTER, 1'b0, 24'sd8388607, 5'd0, 24'sd0);
    push_item(bqc_pkg::KIND_FILTER, 1'b1, -24'sd8388608, 5'd31, -24'sd1);
    push_item(bqc_pkg::KIND_FILTER, 1'b0, 24'sd0, 5'd0, 24'sd0);
    push_item(bqc_pkg::KIND_COEF, 1'b0, 24'sd0, 5'd0, -24'sd8388608);
    push_item(bqc_pkg::KIND_COEF, 1'b1, 24'sd0, 5'd1, 24'sd8388607);
    push_item(bqc_pkg::KIND_COEF, 1'b0, 24'sd0, 5'd2, -24'sd8388608);
    push_item(bqc_pkg::KIND_COEF, 1'b1, 24'sd0, 5'd3, 24'sd8388607);
    for (i = 0; i < 4; i++) push_item(bqc_pkg::KIND_FILTER, 1'b0, 24'sd8388607, 5'd0, 24'sd0);
    for (i = 0; i < 3; i++) push_item(bqc_pkg::KIND_FILTER, 1'b1, -24'sd8388608, 5'd0, 24'sd0);
    push_item(KIND_UNUSED, 1'b0, 24'sd1234, 5'd5, 24'sd77);
    push_item(bqc_pkg::KIND_CLEAR, 1'b0, 24'sd0, 5'd0, 24'sd0);
    push_item(bqc_pkg::KIND_FILTER, 1'b0, 24'sd1, 5'd0, 24'sd0);
    push_item(bqc_pkg::KIND_FILTER, 1'b0, -24'sd1, 5'd0, 24'sd0);
    push_item(bqc_pkg::KIND_COEF, 1'b0, 24'sd0, 5'd31, 24'sd8388607);
    push_item(bqc_pkg::KIND_COEF, 1'b1, 24'sd0, 5'd16, -24'sd8388608);
    push_item(bqc_pkg::KIND_CLEAR, 1'b1, 24'sd0, 5'd0, 24'sd0);
    push_item(bqc_pkg::KIND_FILTER, 1'b1, -24'sd1, 5'd0, 24'sd0);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) idle_pct = 0;
      else idle_pct = (ph % 3 == 0) ? 3 : (ph % 3 == 1) ? 25 : 50;
      write_sections(phase_cfg[ph]);
      for (i = 0; i < SECTIONS; i++) load_stable(i);
      push_item(bqc_pkg::KIND_CLEAR, 1'b0, rand24(), 5'($urandom()), rand24());
      push_item(bqc_pkg::KIND_CLEAR, 1'b1, rand24(), 5'($urandom()), rand24());
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 82) begin
          style = $urandom_range(3);
          case (style)
            0: smp = rand24();
            1: smp = 24'(int'($urandom_range(8192)) - 4096);
            2: smp = $urandom_range(1) ? 24'sd8388607 : -24'sd8388608;
            default: smp = 24'(int'($urandom_range(2097152)) - 1048576);
          endcase
          push_item(bqc_pkg::KIND_FILTER, 1'($urandom_range(1)), smp, 5'($urandom()),
                    rand24());
        end else if (pick < 88) begin
          push_item(bqc_pkg::KIND_COEF, 1'($urandom_range(1)), rand24(), 5'($urandom()),
                    24'(int'($urandom_range(2097152)) - 1048576));
        end else if (pick < 94) begin
          push_item(bqc_pkg::KIND_CLEAR, 1'($urandom_range(1)), rand24(), 5'($urandom()),
                    rand24());
        end else if (pick < 97) begin
          push_item(KIND_UNUSED, 1'($urandom_range(1)), rand24(), 5'($urandom()), rand24());
        end else begin
          push_item(bqc_pkg::KIND_COEF, 1'($urandom_range(1)), rand24(), 5'($urandom()),
                    rand24());
        end
      end
      drain();
    end

    $display("Run covered %0d filtered samples, %0d coefficient writes, %0d clears,",
             results_seen, coef_writes, clears);
    $display("%0d ignored items and %0d section-count settings including 0, 1, 8 and 15.",
             ignored, cfg_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
